// ===== hw/rtl/met_pkg.sv =====
// Shared constants, register codes, sequencer states and config bundle for the escape-time core.
package met_pkg;

  localparam int COORD_FRAC_BITS = 28;
  localparam int COORD_W         = 32;
  // signed operand width of the shared multiplier: covers a 33-bit view span
  // and a Q2.28 iterate
  localparam int MUL_W           = 33;
  localparam int SIZE_W          = 13;
  localparam int MOD_W           = 16;
  localparam int DIVISOR_W       = 16;
  localparam int REG_INDEX_W     = 3;

  localparam logic [COORD_W-1:0] VIEW_LO_RST = COORD_W'(-(64'sd2 <<< COORD_FRAC_BITS));
  localparam logic [COORD_W-1:0] VIEW_HI_RST = COORD_W'(64'sd2 <<< COORD_FRAC_BITS);
  localparam logic [SIZE_W-1:0]  WIDTH_RST   = 13'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST  = 13'd480;
  localparam int                 LIMIT_RST   = 1000;
  localparam logic [MOD_W-1:0]   MODULUS_RST = 16'd1000;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_VIEW_X_MIN      = 3'd0,
    REG_VIEW_X_MAX      = 3'd1,
    REG_VIEW_Y_MIN      = 3'd2,
    REG_VIEW_Y_MAX      = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5,
    REG_ITERATION_LIMIT = 3'd6,
    REG_PALETTE_MODULUS = 3'd7
  } met_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAPX_MUL,
    ST_MAPX_DIV,
    ST_MAPX_WAIT,
    ST_MAPY_MUL,
    ST_MAPY_DIV,
    ST_MAPY_WAIT,
    ST_ITER_XX,
    ST_ITER_YY,
    ST_ITER_XY,
    ST_ITER_UPD,
    ST_MOD_WAIT,
    ST_FINISH
  } met_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] view_x_min;
    logic [COORD_W-1:0] view_x_max;
    logic [COORD_W-1:0] view_y_min;
    logic [COORD_W-1:0] view_y_max;
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
    logic [MOD_W-1:0]   palette_modulus;
  } met_cfg_t;

endpackage

// ===== hw/rtl/met_if.sv =====
// Handshake channels of the escape-time core: pixel requests, results and config writes.
interface met_pixel_if #(parameter int INDEX_WIDTH = 12);
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] pixel_column;
  logic [INDEX_WIDTH-1:0] pixel_row;
  modport source (output valid, pixel_column, pixel_row, input ready);
  modport sink (input valid, pixel_column, pixel_row, output ready);
endinterface

interface met_result_if #(parameter int INDEX_WIDTH = 12, parameter int COUNT_WIDTH = 16);
  logic                       valid;
  logic                       ready;
  logic [INDEX_WIDTH-1:0]     column_out;
  logic [INDEX_WIDTH-1:0]     row_out;
  logic [COUNT_WIDTH-1:0]     iteration_count;
  logic [met_pkg::MOD_W-1:0]  palette_index;
  modport source (output valid, column_out, row_out, iteration_count, palette_index,
                  input ready);
  modport sink (input valid, column_out, row_out, iteration_count, palette_index,
                output ready);
endinterface

interface met_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [met_pkg::REG_INDEX_W-1:0] index;
  logic [met_pkg::COORD_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/met_cfg_regs.sv =====
// Configuration register file: view window, image size, iteration limit, palette modulus.
module met_cfg_regs #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  met_cfg_if.sink                cfg,
  output met_pkg::met_cfg_t      view,
  output logic [COUNT_WIDTH-1:0] iteration_limit
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view.view_x_min      <= met_pkg::VIEW_LO_RST;
      view.view_x_max      <= met_pkg::VIEW_HI_RST;
      view.view_y_min      <= met_pkg::VIEW_LO_RST;
      view.view_y_max      <= met_pkg::VIEW_HI_RST;
      view.image_width     <= met_pkg::WIDTH_RST;
      view.image_height    <= met_pkg::HEIGHT_RST;
      view.palette_modulus <= met_pkg::MODULUS_RST;
      iteration_limit      <= COUNT_WIDTH'(met_pkg::LIMIT_RST);
    end else if (cfg.valid) begin
      case (met_pkg::met_reg_e'(cfg.index))
        met_pkg::REG_VIEW_X_MIN:      view.view_x_min      <= cfg.data;
        met_pkg::REG_VIEW_X_MAX:      view.view_x_max      <= cfg.data;
        met_pkg::REG_VIEW_Y_MIN:      view.view_y_min      <= cfg.data;
        met_pkg::REG_VIEW_Y_MAX:      view.view_y_max      <= cfg.data;
        met_pkg::REG_IMAGE_WIDTH:     view.image_width     <= cfg.data[met_pkg::SIZE_W-1:0];
        met_pkg::REG_IMAGE_HEIGHT:    view.image_height    <= cfg.data[met_pkg::SIZE_W-1:0];
        met_pkg::REG_ITERATION_LIMIT: iteration_limit      <= COUNT_WIDTH'(cfg.data);
        met_pkg::REG_PALETTE_MODULUS: view.palette_modulus <= cfg.data[met_pkg::MOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/met_mul.sv =====
// Shared signed multiplier with a registered product.
module met_mul (
  input  logic                                clk,
  input  logic signed [met_pkg::MUL_W-1:0]    a,
  input  logic signed [met_pkg::MUL_W-1:0]    b,
  output logic signed [2*met_pkg::MUL_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hw/rtl/met_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module met_div #(
  parameter int DIVIDEND_W = 44
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [DIVIDEND_W-1:0]             dividend,
  input  logic [met_pkg::DIVISOR_W-1:0]     divisor,
  output logic                              busy,
  output logic [DIVIDEND_W-1:0]             quotient,
  output logic [met_pkg::DIVISOR_W-1:0]     remainder
);

  localparam int DW  = met_pkg::DIVISOR_W;
  localparam int CNW = $clog2(DIVIDEND_W + 1);

  logic [DW-1:0]         dsor;
  logic [CNW-1:0]        steps;
  logic [DW:0]           trial;
  logic                  fits;

  assign trial = {remainder, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= CNW'(DIVIDEND_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // quotient bits shift in from the right as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsor      <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIVIDEND_W-2:0], fits};
      remainder <= fits ? DW'(trial - {1'b0, dsor}) : trial[DW-1:0];
    end
  end

endmodule

// ===== hw/rtl/mandelbrot_escape_time_core.sv =====
// Mandelbrot escape-time core: maps a pixel into the view window and counts iterations.
// One pixel request at a time: the core maps column and row through the shared multiplier
// and the bit-serial divider, then runs z = z*z + c with one shared multiplier in the
// states ITER_XX, ITER_YY, ITER_XY and ITER_UPD of each iteration, and forms the palette
// index through the divider again (the raw count when the modulus is zero). The result
// sits in an output register, so the next pixel request is taken while a result waits.
module mandelbrot_escape_time_core #(
  parameter int INDEX_WIDTH = 12,
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  met_pixel_if.sink    pixel,
  met_result_if.source result,
  met_cfg_if.sink      cfg
);

  localparam int FRAC = met_pkg::COORD_FRAC_BITS;
  localparam int MW   = met_pkg::MUL_W;
  localparam int PW   = 2 * MW;
  localparam int CXW  = INDEX_WIDTH + 34;
  localparam int DVW  = INDEX_WIDTH + 32;
  localparam int SQW  = 2 * FRAC + 2;
  localparam int DSW  = met_pkg::DIVISOR_W;

  localparam logic signed [CXW-1:0] TWO_C =
    {{(CXW-FRAC-2){1'b0}}, 1'b1, {(FRAC+1){1'b0}}};
  localparam logic signed [CXW-1:0] NEG_TWO_C = -TWO_C;
  localparam logic [SQW:0] FOUR_C = {1'b1, {SQW{1'b0}}};

  met_pkg::met_cfg_t      view;
  logic [COUNT_WIDTH-1:0] limit;

  met_pkg::met_state_t state, state_next;

  logic [INDEX_WIDTH-1:0]  col, row;
  logic signed [CXW-1:0]   cx, cy, x, y;
  logic [SQW-1:0]          xx, yy;
  logic [COUNT_WIDTH-1:0]  count;
  logic                    neg;

  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    prod;
  logic [PW-1:0]           prod_mag;

  logic                    div_start, div_busy;
  logic [DVW-1:0]          div_dividend, div_quot;
  logic [DSW-1:0]          div_divisor, div_rem;

  logic                    load_out, res_valid;
  logic [INDEX_WIDTH-1:0]  col_q, row_q;
  logic [COUNT_WIDTH-1:0]  count_q;
  logic [met_pkg::MOD_W-1:0] palette_q;

  logic signed [MW-1:0]    diff_x, diff_y, x_op, y_op, col_op, row_op;
  logic [DSW-1:0]          div_x, div_y;
  logic                    out_of_range, escaped;
  logic [SQW:0]            mag_sum;
  logic [DVW-1:0]          mod_dividend;
  logic signed [CXW-1:0]   q_ext, q_signed, lo_x_ext, lo_y_ext;
  logic signed [2*FRAC+2:0] xy_full, xy_shift;
  logic signed [CXW-1:0]   x_new, y_new;

  met_cfg_regs #(.COUNT_WIDTH(COUNT_WIDTH)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .view            (view),
    .iteration_limit (limit)
  );

  met_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  met_div #(.DIVIDEND_W(DVW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // view spans and step divisors
  assign diff_x = {view.view_x_max[31], view.view_x_max} - {view.view_x_min[31], view.view_x_min};
  assign diff_y = {view.view_y_max[31], view.view_y_max} - {view.view_y_min[31], view.view_y_min};
  assign div_x  = (view.image_width >= 13'd2) ? DSW'(view.image_width - 1'b1) : DSW'(1);
  assign div_y  = (view.image_height >= 13'd2) ? DSW'(view.image_height - 1'b1) : DSW'(1);
  assign col_op = {{(MW-INDEX_WIDTH){1'b0}}, col};
  assign row_op = {{(MW-INDEX_WIDTH){1'b0}}, row};
  assign x_op   = {{(MW-FRAC-2){x[FRAC+1]}}, x[FRAC+1:0]};
  assign y_op   = {{(MW-FRAC-2){y[FRAC+1]}}, y[FRAC+1:0]};

  assign prod_mag     = prod[PW-1] ? PW'(-prod) : prod;
  assign mod_dividend = DVW'(count);

  // truncating division: divide the magnitude, then restore the sign
  assign q_ext    = {{(CXW-DVW){1'b0}}, div_quot};
  assign q_signed = neg ? -q_ext : q_ext;
  assign lo_x_ext = {{(CXW-32){view.view_x_min[31]}}, view.view_x_min};
  assign lo_y_ext = {{(CXW-32){view.view_y_min[31]}}, view.view_y_min};

  assign out_of_range = (x >= TWO_C) || (x <= NEG_TWO_C) || (y >= TWO_C) || (y <= NEG_TWO_C);
  assign mag_sum      = {1'b0, xx} + {1'b0, prod[SQW-1:0]};
  assign escaped      = mag_sum >= FOUR_C;

  assign xy_full  = prod[2*FRAC+2:0];
  assign xy_shift = xy_full >>> (FRAC - 1);
  assign y_new    = {{(CXW-FRAC-4){xy_shift[FRAC+3]}}, xy_shift[FRAC+3:0]} + cy;
  assign x_new    = {{(CXW-FRAC-2){1'b0}}, xx[SQW-1:FRAC]}
                  - {{(CXW-FRAC-2){1'b0}}, yy[SQW-1:FRAC]} + cx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= met_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    load_out     = 1'b0;
    case (state)
      met_pkg::ST_IDLE: begin
        if (pixel.valid) begin
          state_next = met_pkg::ST_MAPX_MUL;
        end
      end
      met_pkg::ST_MAPX_MUL: begin
        mul_a      = diff_x;
        mul_b      = col_op;
        state_next = met_pkg::ST_MAPX_DIV;
      end
      met_pkg::ST_MAPX_DIV: begin
        div_start    = 1'b1;
        div_dividend = prod_mag[DVW-1:0];
        div_divisor  = div_x;
        state_next   = met_pkg::ST_MAPX_WAIT;
      end
      met_pkg::ST_MAPX_WAIT: begin
        if (!div_busy) begin
          state_next = met_pkg::ST_MAPY_MUL;
        end
      end
      met_pkg::ST_MAPY_MUL: begin
        mul_a      = diff_y;
        mul_b      = row_op;
        state_next = met_pkg::ST_MAPY_DIV;
      end
      met_pkg::ST_MAPY_DIV: begin
        div_start    = 1'b1;
        div_dividend = prod_mag[DVW-1:0];
        div_divisor  = div_y;
        state_next   = met_pkg::ST_MAPY_WAIT;
      end
      met_pkg::ST_MAPY_WAIT: begin
        if (!div_busy) begin
          state_next = met_pkg::ST_ITER_XX;
        end
      end
      met_pkg::ST_ITER_XX: begin
        // stop at the limit or once a coordinate leaves (-2, 2)
        if ((count >= limit) || out_of_range) begin
          div_start    = 1'b1;
          div_dividend = mod_dividend;
          div_divisor  = view.palette_modulus;
          state_next   = met_pkg::ST_MOD_WAIT;
        end else begin
          mul_a      = x_op;
          mul_b      = x_op;
          state_next = met_pkg::ST_ITER_YY;
        end
      end
      met_pkg::ST_ITER_YY: begin
        mul_a      = y_op;
        mul_b      = y_op;
        state_next = met_pkg::ST_ITER_XY;
      end
      met_pkg::ST_ITER_XY: begin
        mul_a = x_op;
        mul_b = y_op;
        if (escaped) begin
          div_start    = 1'b1;
          div_dividend = mod_dividend;
          div_divisor  = view.palette_modulus;
          state_next   = met_pkg::ST_MOD_WAIT;
        end else begin
          state_next = met_pkg::ST_ITER_UPD;
        end
      end
      met_pkg::ST_ITER_UPD: begin
        state_next = met_pkg::ST_ITER_XX;
      end
      met_pkg::ST_MOD_WAIT: begin
        if (!div_busy) begin
          state_next = met_pkg::ST_FINISH;
        end
      end
      met_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!res_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = met_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = met_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      met_pkg::ST_IDLE: begin
        col <= pixel.pixel_column;
        row <= pixel.pixel_row;
      end
      met_pkg::ST_MAPX_DIV, met_pkg::ST_MAPY_DIV: begin
        neg <= prod[PW-1];
      end
      met_pkg::ST_MAPX_WAIT: begin
        cx <= lo_x_ext + q_signed;
      end
      met_pkg::ST_MAPY_WAIT: begin
        cy    <= lo_y_ext + q_signed;
        x     <= '0;
        y     <= '0;
        count <= '0;
      end
      met_pkg::ST_ITER_YY: begin
        xx <= prod[SQW-1:0];
      end
      met_pkg::ST_ITER_XY: begin
        yy <= prod[SQW-1:0];
      end
      met_pkg::ST_ITER_UPD: begin
        x     <= x_new;
        y     <= y_new;
        count <= count + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      col_q     <= col;
      row_q     <= row;
      count_q   <= count;
      palette_q <= (view.palette_modulus == '0) ? met_pkg::MOD_W'(count) : div_rem;
    end
  end

  assign pixel.ready            = (state == met_pkg::ST_IDLE);
  assign result.valid           = res_valid;
  assign result.column_out      = col_q;
  assign result.row_out         = row_q;
  assign result.iteration_count = count_q;
  assign result.palette_index   = palette_q;

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_count_below_limit: assert property (@(posedge clk) disable iff (rst)
    (state == met_pkg::ST_ITER_YY || state == met_pkg::ST_ITER_XY ||
     state == met_pkg::ST_ITER_UPD) |-> (count < limit))
    else $error("iteration count ran past the limit");

  a_square_operands: assert property (@(posedge clk) disable iff (rst)
    (state == met_pkg::ST_ITER_YY) |-> !out_of_range)
    else $error("squares formed on an out-of-range iterate");
`endif

endmodule
